// ----- design/bvc_pkg.sv -----
// Package for the box voxel collision resolver: widths, codes and shared types.
`default_nettype none
package bvc_pkg;

    // Defaults for the top level parameters
    localparam int GRID_DIM_DEF = 32;
    localparam int MAX_ITER_DEF = 4;
    localparam int MAX_SPAN_DEF = 4;

    // Fixed field widths
    localparam int CW      = 32;   // centre and velocity, signed Q16.16
    localparam int HW      = 24;   // half extent, unsigned Q8.16
    localparam int EW      = 34;   // box bound, signed
    localparam int LW      = 19;   // voxel coordinate, signed
    localparam int OW      = 40;   // overlap arithmetic, signed
    localparam int PEN_W   = 21;   // positive overlap, at most one voxel edge
    localparam int SZ_W    = 3;    // voxel size register
    localparam int IDX_W   = 15;   // voxel index field
    localparam int FRAC_W  = 16;   // fraction bits
    localparam int SZ_MAX  = 4;    // largest voxel size exponent
    localparam int IN_W    = 280;  // s_tdata width
    localparam int OUT_W   = 200;  // m_tdata width

    // Input kinds carried in tuser
    localparam logic ACT_RESOLVE = 1'b0;
    localparam logic ACT_WRITE   = 1'b1;

    // Push axis codes
    typedef enum logic [1:0] {
        AX_X = 2'd0,
        AX_Y = 2'd1,
        AX_Z = 2'd2
    } axis_t;

    // One walked voxel, registered alongside the occupancy read
    typedef struct packed {
        logic                   vld;
        logic                   in_grid;
        logic [2:0]             ov_pos;
        logic [2:0][PEN_W-1:0]  ov;
        logic [2:0]             sgn;     // 1: centre on or above voxel centre
    } probe_t;

    // Best contact of the current pass
    typedef struct packed {
        logic               found;
        logic [PEN_W-1:0]   pen;
        axis_t              axis;
        logic               sgn;
    } contact_t;

endpackage
`default_nettype wire

// ----- design/bvc_ram.sv -----
// Generic single-port synchronous RAM with registered read.
`default_nettype none
module bvc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 32768,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    addr,
    input  wire logic [WIDTH-1:0] wdata,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read first port, one access a cycle
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
`default_nettype wire

// ----- design/bvc_contact.sv -----
// Contact selection: picks the least-penetration solid voxel of a pass.
`default_nettype none
module bvc_contact
    import bvc_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     start,     // clears the best contact for a new pass
    input  wire probe_t   probe,
    input  wire logic     solid,
    output contact_t      best
);

    contact_t best_reg, best_next;
    logic     hit;
    axis_t    ax;
    logic [PEN_W-1:0] pen;

    // Axis of least overlap, ties towards x then y
    always_comb begin
        if (probe.ov[0] <= probe.ov[1] && probe.ov[0] <= probe.ov[2]) begin
            ax = AX_X;
        end else if (probe.ov[1] <= probe.ov[2]) begin
            ax = AX_Y;
        end else begin
            ax = AX_Z;
        end
        pen = probe.ov[ax];
        hit = probe.vld && probe.in_grid && solid && (&probe.ov_pos);
    end

    // First walked wins on equal penetration
    always_comb begin
        best_next = best_reg;
        if (start) begin
            best_next.found = 1'b0;
        end else if (hit && (!best_reg.found || pen < best_reg.pen)) begin
            best_next.found = 1'b1;
            best_next.pen   = pen;
            best_next.axis  = ax;
            best_next.sgn   = probe.sgn[ax];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_reg.found <= 1'b0;
            best_reg.pen   <= '0;
            best_reg.axis  <= AX_X;
            best_reg.sgn   <= 1'b0;
        end else begin
            best_reg <= best_next;
        end
    end

    assign best = best_reg;

endmodule
`default_nettype wire

// ----- design/box_voxel_collision_resolver_unit.sv -----
// Top level of the box voxel collision resolver.
//
// Channel  | Dir | Signals                              | Transfer
// s_       | in  | s_tvalid s_tready s_tdata s_tuser    | tvalid and tready high
// m_       | out | m_tvalid m_tready m_tdata            | tvalid and tready high
// cfg_     | in  | cfg_valid cfg_ready cfg_data         | valid and ready, ready always high
//
// A voxel write goes to the RAM as it is accepted. A resolve takes up to MAX_ITER
// passes, each walking Sx*Sy*Sz voxels (S the clipped span, at most MAX_SPAN per
// axis), then loads the output register; its pace is bound by the single
// occupancy RAM port, read once per walked voxel.
// After reset the occupancy RAM is cleared, one entry a cycle, all GRID_DIM^3
// entries (32768 at the defaults); no item is taken meanwhile.
// The next item is taken while a result waits in the output register; a
// finished resolve holds until that register is free.
`default_nettype none
module box_voxel_collision_resolver_unit
    import bvc_pkg::*;
#(
    parameter int GRID_DIM = GRID_DIM_DEF,
    parameter int MAX_ITER = MAX_ITER_DEF,
    parameter int MAX_SPAN = MAX_SPAN_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    // config
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [SZ_W-1:0]  cfg_data,    // voxel_size_log2
    // input stream
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    // center_x, center_y, center_z, half_x, half_y, half_z, vel_x, vel_y,
    // vel_z, voxel_index, voxel_solid
    input  wire logic [IN_W-1:0]  s_tdata,
    input  wire logic             s_tuser,     // action
    // result stream
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    // out_center_x/y/z, out_vel_x/y/z, grounded, collided, zero pad
    output logic [OUT_W-1:0]      m_tdata
);

    localparam int DEPTH = GRID_DIM * GRID_DIM * GRID_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int SCW   = $clog2(MAX_SPAN);
    localparam int ITW   = $clog2(MAX_ITER + 1);

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_SETUP = 7'b0000100,
        ST_WALK  = 7'b0001000,
        ST_DRAIN = 7'b0010000,
        ST_APPLY = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [SZ_W-1:0]      size_reg;
    logic [AW-1:0]        clr_reg;
    logic [ITW-1:0]       iter_reg;
    logic                 grounded_reg, collided_reg;
    logic signed [CW-1:0] c_reg [3];
    logic signed [CW-1:0] v_reg [3];
    logic [HW-1:0]        h_reg [3];
    logic signed [EW-1:0] emin_reg [3];
    logic signed [EW-1:0] emax_reg [3];
    logic signed [LW-1:0] lo_reg [3];
    logic [SCW-1:0]       n_reg [3];
    logic [SCW-1:0]       o_reg [3];
    probe_t               probe_reg, probe_next;
    contact_t             best;
    logic                 m_tvalid_reg;
    logic [OUT_W-1:0]     m_tdata_reg;

    logic                 ram_we;
    logic [AW-1:0]        ram_addr;
    logic [0:0]           ram_wdata, ram_rdata;

    logic [4:0]           shift;
    logic signed [OW-1:0] vs;
    logic                 s_fire, walk_last;
    logic [AW-1:0]        walk_addr;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // Voxel edge in Q16.16, size saturated at the largest step
    always_comb begin
        shift = (size_reg > SZ_W'(SZ_MAX)) ? 5'(FRAC_W + SZ_MAX) : 5'(FRAC_W) + 5'(size_reg);
        vs    = OW'(1) <<< shift;
    end

    // Walk address and per-voxel overlap, registered next to the RAM read
    always_comb begin
        logic signed [LW-1:0] crd [3];
        logic signed [OW-1:0] vmin, vmax, lo_b, hi_b, ov, vc;
        logic [31:0]          idx;
        probe_next         = '0;
        probe_next.vld     = (state_reg == ST_WALK);
        probe_next.in_grid = 1'b1;
        for (int a = 0; a < 3; a++) begin
            crd[a] = lo_reg[a] + LW'(o_reg[a]);
            if (crd[a] < 0 || crd[a] >= LW'(GRID_DIM)) begin
                probe_next.in_grid = 1'b0;
            end
            vmin = OW'(crd[a]) <<< shift;
            vmax = vmin + vs;
            lo_b = (OW'(emin_reg[a]) > vmin) ? OW'(emin_reg[a]) : vmin;
            hi_b = (OW'(emax_reg[a]) < vmax) ? OW'(emax_reg[a]) : vmax;
            ov   = hi_b - lo_b;
            vc   = vmin + (vs >>> 1);
            probe_next.ov_pos[a] = (ov > 0);
            probe_next.ov[a]     = PEN_W'(ov);
            probe_next.sgn[a]    = (OW'(c_reg[a]) - vc >= 0);
        end
        idx = 32'(unsigned'(crd[0])) + 32'(GRID_DIM) * 32'(unsigned'(crd[1]))
            + 32'(GRID_DIM * GRID_DIM) * 32'(unsigned'(crd[2]));
        walk_addr = AW'(idx);
        walk_last = (o_reg[0] == n_reg[0]) && (o_reg[1] == n_reg[1])
                 && (o_reg[2] == n_reg[2]);
    end

    // RAM port: clearing pass, voxel writes, walk reads
    always_comb begin
        ram_we    = 1'b0;
        ram_wdata = 1'b0;
        ram_addr  = walk_addr;
        if (state_reg == ST_CLEAR) begin
            ram_we   = 1'b1;
            ram_addr = clr_reg;
        end else if (s_fire && s_tuser == ACT_WRITE) begin
            ram_addr  = AW'(s_tdata[278:264]);
            ram_wdata = s_tdata[279];
            ram_we    = (32'(s_tdata[278:264]) < 32'(DEPTH));
        end
    end

    bvc_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_occ (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    bvc_contact u_contact (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (state_reg == ST_SETUP),
        .probe   (probe_reg),
        .solid   (ram_rdata[0]),
        .best    (best)
    );

    // Sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (clr_reg == AW'(DEPTH - 1)) state_next = ST_IDLE;
            ST_IDLE:  if (s_fire && s_tuser == ACT_RESOLVE) state_next = ST_SETUP;
            ST_SETUP: state_next = ST_WALK;
            ST_WALK:  if (walk_last) state_next = ST_DRAIN;
            ST_DRAIN: state_next = ST_APPLY;
            ST_APPLY: begin
                if (!best.found || iter_reg == ITW'(MAX_ITER - 1)) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_SETUP;
                end
            end
            ST_OUT:   if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            default:  state_next = ST_CLEAR;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            size_reg     <= '0;
            m_tvalid_reg <= 1'b0;
            probe_reg    <= '0;
        end else begin
            state_reg <= state_next;
            probe_reg <= probe_next;
            if (state_reg == ST_CLEAR) begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (cfg_valid) begin
                size_reg <= cfg_data;
            end
            if (state_reg == ST_OUT && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        logic signed [EW-1:0] emin_w, emax_w, lo_w, hi_w, span;
        logic signed [EW-1:0] sum;
        axis_t ax;
        if (s_fire && s_tuser == ACT_RESOLVE) begin
            for (int a = 0; a < 3; a++) begin
                c_reg[a] <= s_tdata[a*CW +: CW];
                h_reg[a] <= s_tdata[3*CW + a*HW +: HW];
                v_reg[a] <= s_tdata[3*CW + 3*HW + a*CW +: CW];
            end
            iter_reg     <= '0;
            grounded_reg <= 1'b0;
            collided_reg <= 1'b0;
        end
        // Box bounds and clipped span for this pass, floor by arithmetic shift
        if (state_reg == ST_SETUP) begin
            for (int a = 0; a < 3; a++) begin
                emin_w = EW'(c_reg[a]) - signed'(EW'(h_reg[a]));
                emax_w = EW'(c_reg[a]) + signed'(EW'(h_reg[a]));
                emin_reg[a] <= emin_w;
                emax_reg[a] <= emax_w;
                lo_w = emin_w >>> shift;
                hi_w = emax_w >>> shift;
                span = hi_w - lo_w;
                lo_reg[a] <= LW'(lo_w);
                n_reg[a]  <= (span > EW'(MAX_SPAN - 1)) ? SCW'(MAX_SPAN - 1) : SCW'(span);
                o_reg[a]  <= '0;
            end
        end
        // Walk counters, z innermost
        if (state_reg == ST_WALK) begin
            if (o_reg[2] != n_reg[2]) begin
                o_reg[2] <= o_reg[2] + SCW'(1);
            end else begin
                o_reg[2] <= '0;
                if (o_reg[1] != n_reg[1]) begin
                    o_reg[1] <= o_reg[1] + SCW'(1);
                end else begin
                    o_reg[1] <= '0;
                    o_reg[0] <= o_reg[0] + SCW'(1);
                end
            end
        end
        // Push out, clear inward velocity
        if (state_reg == ST_APPLY && best.found) begin
            ax  = best.axis;
            sum = best.sgn ? EW'(c_reg[ax]) + EW'(best.pen)
                           : EW'(c_reg[ax]) - EW'(best.pen);
            if (sum > EW'(32'sh7FFFFFFF)) begin
                c_reg[ax] <= 32'sh7FFFFFFF;
            end else if (sum < -EW'(33'sh080000000)) begin
                c_reg[ax] <= 32'sh80000000;
            end else begin
                c_reg[ax] <= CW'(sum);
            end
            if ((best.sgn && v_reg[ax] < 0) || (!best.sgn && v_reg[ax] > 0)) begin
                v_reg[ax] <= '0;
            end
            if (ax == AX_Y && best.sgn && v_reg[1] <= 0) begin
                grounded_reg <= 1'b1;
            end
            collided_reg <= 1'b1;
            iter_reg     <= iter_reg + ITW'(1);
        end
        // Result register
        if (state_reg == ST_OUT && (!m_tvalid_reg || m_tready)) begin
            m_tdata_reg <= {6'b0, collided_reg, grounded_reg,
                            v_reg[2], v_reg[1], v_reg[0], c_reg[2], c_reg[1], c_reg[0]};
        end
    end

endmodule
`default_nettype wire

// ----- design/bvc_checker.sv -----
// Port-level checker for the box voxel collision resolver, bound to the top.
`default_nettype none
module bvc_checker
    import bvc_pkg::*;
(
    input wire logic             aclk,
    input wire logic             aresetn,
    input wire logic             s_tvalid,
    input wire logic             s_tready,
    input wire logic             m_tvalid,
    input wire logic             m_tready,
    input wire logic [OUT_W-1:0] m_tdata
);

    // Clearing pass: no input taken just after reset
    a_clear_blocks: assert property (@(posedge aclk) !aresetn |=> !s_tready)
        else $error("input taken during clearing pass");

    // No result out of reset
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Grounded only with a collision
    a_ground: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[192] && !m_tdata[193]))
        else $error("grounded without collision");

endmodule

bind box_voxel_collision_resolver_unit bvc_checker u_bvc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

// ----- tb/box_voxel_collision_resolver_unit_test.sv -----
// Self-checking testbench for the box voxel collision resolver, streaming ports.
`default_nettype none
module box_voxel_collision_resolver_unit_test;
    import bvc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID   = 32;
    localparam int PASSES = 4;
    localparam int SPAN   = 4;
    localparam int ONE    = 65536;   // 1.0 in Q16.16 at the smallest voxel size

    typedef struct {
        logic                  act;
        logic signed [31:0]    cen [3];
        logic [23:0]           half [3];
        logic signed [31:0]    vel [3];
        logic [IDX_W-1:0]      vox_idx;
        logic                  vox_solid;
    } box_item_t;

    typedef struct {
        logic signed [31:0] cen [3];
        logic signed [31:0] vel [3];
        logic               grounded;
        logic               collided;
    } contact_res_t;

    typedef struct {
        box_item_t    it;
        bit           typed;
        contact_res_t res;
    } stim_row_t;

    logic             aclk;
    logic             aresetn;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [SZ_W-1:0]  cfg_data;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;
    logic             s_tuser;
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;

    // Predictor state: occupancy copy and voxel size register
    bit              occ_map [GRID*GRID*GRID];
    logic [SZ_W-1:0] size_log2;

    contact_res_t resolved_q [$];
    int           n_fail;
    int           n_sent;
    int           n_results;
    int           n_hits;
    int           n_grounded;
    bit           hold_once;
    bit           quiet;

    box_voxel_collision_resolver_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Run limit
    initial begin
        #60ms;
        $display("CHECK FAILED");
        $finish;
    end

    // Predictor: apply one accepted item, return the result it causes if any
    function automatic void predict_item(input box_item_t it, output bit has,
                                         output contact_res_t r);
        longint c [3], h [3], v [3], emin [3], emax [3], lo [3], hi [3];
        longint ov [3], idx3 [3];
        longint vs, best, vmin, vc, nc;
        longint ix, iy, iz;
        int sh, ax, bax, bsg, a, n;
        bit found, grd, col;
        has = 0;
        r = '{default: 0};
        if (it.act == ACT_WRITE) begin
            occ_map[it.vox_idx] = it.vox_solid;
            return;
        end
        for (a = 0; a < 3; a++) begin
            c[a] = longint'(it.cen[a]);
            h[a] = longint'({8'd0, it.half[a]});
            v[a] = longint'(it.vel[a]);
        end
        sh = 16 + ((size_log2 > SZ_MAX) ? SZ_MAX : int'(size_log2));
        vs = longint'(1) << sh;
        grd = 0;
        col = 0;
        for (n = 0; n < PASSES; n++) begin
            found = 0;
            best = 0;
            bax = 0;
            bsg = 1;
            for (a = 0; a < 3; a++) begin
                emin[a] = c[a] - h[a];
                emax[a] = c[a] + h[a];
                lo[a] = emin[a] >>> sh;
                hi[a] = emax[a] >>> sh;
                if (hi[a] > lo[a] + SPAN - 1) hi[a] = lo[a] + SPAN - 1;
            end
            // walk x outermost, z innermost
            for (ix = lo[0]; ix <= hi[0]; ix++)
                for (iy = lo[1]; iy <= hi[1]; iy++)
                    for (iz = lo[2]; iz <= hi[2]; iz++) begin
                        if (ix < 0 || iy < 0 || iz < 0) continue;
                        if (ix >= GRID || iy >= GRID || iz >= GRID) continue;
                        if (!occ_map[ix + GRID * iy + GRID * GRID * iz]) continue;
                        idx3[0] = ix;
                        idx3[1] = iy;
                        idx3[2] = iz;
                        for (a = 0; a < 3; a++) begin
                            vmin = idx3[a] * vs;
                            ov[a] = ((emax[a] < vmin + vs) ? emax[a] : vmin + vs)
                                  - ((emin[a] > vmin) ? emin[a] : vmin);
                        end
                        if (ov[0] <= 0 || ov[1] <= 0 || ov[2] <= 0) continue;
                        if (ov[0] <= ov[1] && ov[0] <= ov[2]) ax = 0;
                        else if (ov[1] <= ov[2]) ax = 1;
                        else ax = 2;
                        if (!found || ov[ax] < best) begin
                            vc = idx3[ax] * vs + vs / 2;
                            best = ov[ax];
                            bax = ax;
                            bsg = (c[ax] - vc >= 0) ? 1 : -1;
                            found = 1;
                        end
                    end
            if (!found) break;
            col = 1;
            nc = c[bax] + ((bsg > 0) ? best : -best);
            if (nc > 64'sd2147483647) nc = 64'sd2147483647;
            if (nc < -64'sd2147483648) nc = -64'sd2147483648;
            c[bax] = nc;
            if ((bsg > 0 && v[bax] < 0) || (bsg < 0 && v[bax] > 0)) v[bax] = 0;
            if (bax == AX_Y && bsg > 0 && v[1] <= 0) grd = 1;
        end
        for (a = 0; a < 3; a++) begin
            r.cen[a] = c[a][31:0];
            r.vel[a] = v[a][31:0];
        end
        r.grounded = grd;
        r.collided = col;
        has = 1;
    endfunction

    function automatic logic [IN_W-1:0] pack_item(input box_item_t it);
        return {it.vox_solid, it.vox_idx, it.vel[2], it.vel[1], it.vel[0],
                it.half[2], it.half[1], it.half[0], it.cen[2], it.cen[1], it.cen[0]};
    endfunction

    function automatic box_item_t make_box(input int cx, input int cy, input int cz,
                                           input int hx, input int hy, input int hz,
                                           input int vx, input int vy, input int vz);
        box_item_t it;
        it.act = ACT_RESOLVE;
        it.cen = '{cx, cy, cz};
        it.half = '{hx[23:0], hy[23:0], hz[23:0]};
        it.vel = '{vx, vy, vz};
        it.vox_idx = '0;
        it.vox_solid = 1'b0;
        return it;
    endfunction

    function automatic box_item_t make_write(input int idx, input bit solid);
        box_item_t it;
        it = make_box(0, 0, 0, 0, 0, 0, 0, 0, 0);
        it.act = ACT_WRITE;
        it.vox_idx = idx[IDX_W-1:0];
        it.vox_solid = solid;
        return it;
    endfunction

    // A result that passes through untouched
    function automatic contact_res_t unchanged(input box_item_t it);
        contact_res_t r;
        r.cen = it.cen;
        r.vel = it.vel;
        r.grounded = 1'b0;
        r.collided = 1'b0;
        return r;
    endfunction

    // Sender: one transfer, then the drawn gap
    task automatic send_item(input box_item_t it, input bit typed, input contact_res_t tr);
        bit has;
        contact_res_t r;
        int gap;
        @(negedge aclk);
        s_tdata  <= pack_item(it);
        s_tuser  <= it.act;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_item(it, has, r);
        if (has) resolved_q.push_back(typed ? tr : r);
        n_sent++;
        gap = quiet ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (resolved_q.size() != 0) @(negedge aclk);
        // a trailing voxel write may still be in flight
        repeat (20) @(negedge aclk);
    endtask

    task automatic write_size(input int sz);
        drain_results();
        cfg_data  <= sz[SZ_W-1:0];
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        size_log2 = sz[SZ_W-1:0];
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Random item: mostly boxes and writes clustered in the low corner of the grid
    function automatic box_item_t random_item();
        box_item_t it;
        int sel, vsz, a, lim;
        vsz = 1 << (16 + ((size_log2 > SZ_MAX) ? SZ_MAX : int'(size_log2)));
        sel = $urandom_range(0, 99);
        if (sel < 6) begin
            // raw noise across every field bit
            it.act = 1'($urandom_range(0, 1));
            for (a = 0; a < 3; a++) begin
                it.cen[a] = $urandom;
                it.half[a] = 24'($urandom);
                it.vel[a] = $urandom;
            end
            it.vox_idx = IDX_W'($urandom);
            it.vox_solid = 1'($urandom);
        end else if (sel < 40) begin
            if ($urandom_range(0, 9) == 0)
                it = make_write($urandom_range(0, 32767), $urandom_range(0, 1) != 0);
            else
                it = make_write($urandom_range(0, 7) + GRID * $urandom_range(0, 7)
                                + GRID * GRID * $urandom_range(0, 7),
                                $urandom_range(0, 3) != 0);
        end else begin
            it = make_box(0, 0, 0, 0, 0, 0, 0, 0, 0);
            lim = (2 * vsz > 24'hFFFFFF) ? 24'hFFFFFF : 2 * vsz;
            for (a = 0; a < 3; a++) begin
                it.cen[a] = $urandom_range(0, 10 * vsz) - vsz;
                it.half[a] = 24'($urandom_range(0, lim));
                if ($urandom_range(0, 3) == 0) begin
                    // snap to half and quarter voxels for ties and centred pushes
                    it.cen[a] = (it.cen[a] / (vsz / 2)) * (vsz / 2);
                    it.half[a] = 24'((int'(it.half[a]) / (vsz / 4)) * (vsz / 4));
                end
                it.vel[a] = ($urandom_range(0, 4) == 0) ? $urandom
                                                        : $urandom_range(0, 2 * ONE) - ONE;
            end
            it.vox_idx = IDX_W'($urandom);
            it.vox_solid = 1'($urandom);
        end
        return it;
    endfunction

    // Receiver: drawn stalls, with one long hold-off on request
    initial begin
        int w;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            w = quiet ? 0 : $urandom_range(0, 19);
            if (hold_once) begin
                w = 2000;
                hold_once = 0;
            end
            @(negedge aclk);
            if (w > 0) begin
                m_tready <= 1'b0;
                repeat (w) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    // Result checker
    always @(posedge aclk) begin
        contact_res_t e;
        logic signed [31:0] got;
        int a;
        if (aresetn && m_tvalid && m_tready) begin
            n_results++;
            if (resolved_q.size() == 0) begin
                $display("%0t: unexpected result %h", $realtime, m_tdata);
                n_fail++;
            end else begin
                e = resolved_q.pop_front();
                for (a = 0; a < 3; a++) begin
                    got = m_tdata[32*a +: 32];
                    if (got !== e.cen[a]) begin
                        $display("%0t: out_center[%0d] expected %h got %h",
                                 $realtime, a, e.cen[a], got);
                        n_fail++;
                    end
                    got = m_tdata[96 + 32*a +: 32];
                    if (got !== e.vel[a]) begin
                        $display("%0t: out_vel[%0d] expected %h got %h",
                                 $realtime, a, e.vel[a], got);
                        n_fail++;
                    end
                end
                if (m_tdata[192] !== e.grounded) begin
                    $display("%0t: grounded expected %b got %b",
                             $realtime, e.grounded, m_tdata[192]);
                    n_fail++;
                end
                if (m_tdata[193] !== e.collided) begin
                    $display("%0t: collided expected %b got %b",
                             $realtime, e.collided, m_tdata[193]);
                    n_fail++;
                end
                n_hits += e.collided;
                n_grounded += e.grounded;
            end
        end
    end

    // Stimulus
    initial begin
        stim_row_t rows [$];
        stim_row_t row;
        box_item_t it;
        int sizes [8] = '{0, 4, 1, 7, 2, 3, 5, 0};
        int p, k, guard;
        contact_res_t none;
        n_fail = 0;
        n_sent = 0;
        n_results = 0;
        n_hits = 0;
        n_grounded = 0;
        hold_once = 0;
        quiet = 0;
        none = '{default: 0};
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = ACT_RESOLVE;
        size_log2 = '0;
        foreach (occ_map[k]) occ_map[k] = 0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed table at reset size: one voxel edge is 1.0
        it = make_box(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 0,
                      32'h80000000, 32'h7FFFFFFF, 0);
        rows.push_back('{it, 1, unchanged(it)});
        it = make_box(32'h80000000, 32'h80000000, 32'h80000000, 24'hFFFFFF, 24'hFFFFFF,
                      24'hFFFFFF, 32'h7FFFFFFF, 32'h80000000, -1);
        rows.push_back('{it, 1, unchanged(it)});
        rows.push_back('{make_write(0, 1), 0, none});
        // resting on voxel 0 from above, falling: upward push, grounded
        rows.push_back('{make_box(ONE/2, ONE + ONE*2/5, ONE/2, ONE/2, ONE/2, ONE/2,
                                  0, -ONE, 0), 0, none});
        // touching faces only
        it = make_box(ONE + ONE/2, ONE/2, ONE/2, ONE/2, ONE/2, ONE/2, -ONE, 0, 0);
        rows.push_back('{it, 1, unchanged(it)});
        // centre on the voxel centre: tie to x, push toward +
        rows.push_back('{make_box(ONE/2, ONE/2, ONE/2, ONE/2, ONE/2, ONE/2, ONE, ONE, ONE),
                         0, none});
        rows.push_back('{make_write(32767, 1), 0, none});
        rows.push_back('{make_box(31*ONE + ONE/2, 31*ONE + ONE/2, 31*ONE + ONE/4,
                                  ONE/2, ONE/2, ONE/2, 0, 0, ONE), 0, none});
        // box reaching beyond the grid edge
        rows.push_back('{make_box(32*ONE, 32*ONE, 32*ONE, ONE, ONE, ONE, ONE, ONE, ONE),
                         0, none});
        rows.push_back('{make_write(0, 0), 0, none});
        it = make_box(ONE/2, ONE/2, ONE/2, ONE/2, ONE/2, ONE/2, 5, 6, 7);
        it.vox_idx = '1;
        it.vox_solid = 1'b1;
        rows.push_back('{it, 1, unchanged(it)});
        // negative coordinates lie outside the grid
        rows.push_back('{make_write(1 + GRID + GRID*GRID, 1), 0, none});
        it = make_box(-3*ONE, -3*ONE, -3*ONE, 2*ONE, 2*ONE, 2*ONE, ONE, ONE, ONE);
        rows.push_back('{it, 1, unchanged(it)});
        // long box clipped to the span bound: the walk stays below the grid, no contact
        rows.push_back('{make_box(2*ONE, ONE + ONE/2, ONE + ONE/2, 24'hFFFFFF, ONE/2,
                                  ONE*3/4, 0, 0, 0), 0, none});
        rows.push_back('{make_write(2 + GRID + GRID*GRID, 1), 0, none});
        rows.push_back('{make_box(2*ONE, ONE + ONE/2, ONE + ONE/2, ONE*3/2, ONE/2,
                                  ONE/2, -ONE, ONE, -ONE), 0, none});
        foreach (rows[k]) begin
            row = rows[k];
            send_item(row.it, row.typed, row.res);
        end

        // Random phases across voxel sizes
        for (p = 0; p < 8; p++) begin
            write_size(sizes[p]);
            quiet = (p == 2);
            if (p == 3) hold_once = 1;
            for (k = 0; k < 135; k++) send_item(random_item(), 0, none);
        end
        quiet = 0;

        @(negedge aclk);
        s_tvalid <= 1'b0;
        guard = 0;
        while (resolved_q.size() != 0 && guard < 100000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (300) @(posedge aclk);
        if (resolved_q.size() != 0) begin
            $display("%0t: %0d results never arrived", $realtime, resolved_q.size());
            n_fail++;
        end
        $display("Sent %0d items over 8 voxel sizes, %0d resolves checked,", n_sent, n_results);
        $display("%0d with contact and %0d grounded; %0d mismatches", n_hits, n_grounded,
                 n_fail);
        if (n_fail == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire
